[hdl/agod_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the accelerometer gesture/orientation detector.
// No dependencies.
package agod_pkg;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SHAKE  = 2'd1;
  localparam logic [1:0] EV_SUDDEN = 2'd2;

  localparam logic [2:0] OR_UNKNOWN   = 3'd0;
  localparam logic [2:0] OR_FLAT      = 3'd1;
  localparam logic [2:0] OR_UPSIDE    = 3'd2;
  localparam logic [2:0] OR_PORTRAIT  = 3'd3;
  localparam logic [2:0] OR_PORT_INV  = 3'd4;
  localparam logic [2:0] OR_LAND_RT   = 3'd5;
  localparam logic [2:0] OR_LAND_LT   = 3'd6;

  localparam logic [2:0] CFG_MOTION_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_SHAKE_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_COOLDOWN_MS     = 3'd2;
  localparam logic [2:0] CFG_OFFSET_X        = 3'd3;
  localparam logic [2:0] CFG_OFFSET_Y        = 3'd4;
  localparam logic [2:0] CFG_OFFSET_Z        = 3'd5;

  localparam logic        ENABLE_RST    = 1'b1;
  localparam logic [14:0] THRESHOLD_RST = 15'd2560;
  localparam logic [15:0] COOLDOWN_RST  = 16'd500;

  // limits in 1/128 m/s^2 units
  localparam int ORIENT_LIMIT  = 896;
  localparam int SUDDEN_LIMIT  = 1536;
  localparam int STILL_LOW_SQ  = 1271663;
  localparam int STILL_HIGH_SQ = 1914570;

  localparam int QUEUE_DEPTH = 4;

  // per-word classification handed from the front end to the back end
  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [31:0] mag_sq;
    logic [2:0]  orientation;
    logic        stationary;
    logic        over_thr;
    logic        sudden;
  } agod_cls_t;

endpackage

[hdl/agod_fifo.sv]
`timescale 1ns / 1ps
// Small FIFO between front end and back end.
// Generic width and depth; no package dependency.
module agod_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo count above depth");

endmodule

[hdl/agod_front.sv]
`timescale 1ns / 1ps
// Front end: offset correction, squares, magnitude and classification pipeline.
// Uses agod_pkg; feeds agod_fifo.
module agod_front
  import agod_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic signed [AW-1:0] in_raw_x,
  input  logic signed [AW-1:0] in_raw_y,
  input  logic signed [AW-1:0] in_raw_z,
  input  logic [31:0]          in_now_ms,
  input  logic signed [AW-1:0] offset_x,
  input  logic signed [AW-1:0] offset_y,
  input  logic signed [AW-1:0] offset_z,
  input  logic [14:0]          shake_threshold,
  output logic                 push_valid,
  input  logic                 push_ready,
  output agod_cls_t            push_cls,
  output logic [3*AW-1:0]      push_axes
);

  localparam int SQW  = 2 * AW;
  localparam int SW   = 2 * AW + 1;
  localparam int CMPW = (SW > 32) ? SW : 32;

  function automatic logic signed [AW-1:0] sat_sub(logic signed [AW-1:0] a,
                                                   logic signed [AW-1:0] b);
    logic signed [AW:0] d;
    d = {a[AW-1], a} - {b[AW-1], b};
    if (d[AW] != d[AW-1]) begin
      return d[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end
    return d[AW-1:0];
  endfunction

  function automatic logic [AW:0] abs_ext(logic signed [AW-1:0] v);
    logic signed [AW:0] e;
    e = {v[AW-1], v};
    return v[AW-1] ? $unsigned(-e) : $unsigned(e);
  endfunction

  function automatic logic signed [31:0] sx32(logic signed [AW-1:0] v);
    return {{(32-AW){v[AW-1]}}, v};
  endfunction

  // stage 1: corrected axes
  logic                 s1_v_r, s1_kind_r;
  logic [31:0]          s1_now_r;
  logic signed [AW-1:0] s1_x_r, s1_y_r, s1_z_r;
  // stage 2: squares, orientation, sudden flag
  logic                 s2_v_r, s2_kind_r;
  logic [31:0]          s2_now_r;
  logic signed [AW-1:0] s2_x_r, s2_y_r, s2_z_r;
  logic [2*AW-1:0]      s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [2:0]           s2_orient_r;
  logic                 s2_sudden_r;
  // stage 3: magnitude and compares, queue input
  logic                 s3_v_r;
  agod_cls_t            s3_cls_r;
  logic [3*AW-1:0]      s3_axes_r;

  logic [29:0]          thr_sq_r;
  logic                 s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy   = !s3_v_r || push_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  assign push_valid = s3_v_r;
  assign push_cls   = s3_cls_r;
  assign push_axes  = s3_axes_r;

  // stage 2 combinational
  logic [AW:0]            ax, ay, az;
  logic [2:0]             orient_c;
  logic                   sudden_c;
  logic signed [2*AW-1:0] px, py, pz;

  always_comb begin
    ax = abs_ext(s1_x_r);
    ay = abs_ext(s1_y_r);
    az = abs_ext(s1_z_r);
    px = SQW'(s1_x_r) * SQW'(s1_x_r);
    py = SQW'(s1_y_r) * SQW'(s1_y_r);
    pz = SQW'(s1_z_r) * SQW'(s1_z_r);
    orient_c = OR_UNKNOWN;
    if (az > ax && az > ay) begin
      if (sx32(s1_z_r) > ORIENT_LIMIT) begin
        orient_c = OR_FLAT;
      end else if (sx32(s1_z_r) < -ORIENT_LIMIT) begin
        orient_c = OR_UPSIDE;
      end
    end else if (ay > ax && ay > az) begin
      if (sx32(s1_y_r) > ORIENT_LIMIT) begin
        orient_c = OR_PORTRAIT;
      end else if (sx32(s1_y_r) < -ORIENT_LIMIT) begin
        orient_c = OR_PORT_INV;
      end
    end else if (ax > ay && ax > az) begin
      if (sx32(s1_x_r) > ORIENT_LIMIT) begin
        orient_c = OR_LAND_RT;
      end else if (sx32(s1_x_r) < -ORIENT_LIMIT) begin
        orient_c = OR_LAND_LT;
      end
    end
    sudden_c = (32'(ax) > SUDDEN_LIMIT) || (32'(ay) > SUDDEN_LIMIT) ||
               (32'(az) > SUDDEN_LIMIT);
  end

  // stage 3 combinational
  logic [SW-1:0]   sum_c;
  logic [CMPW-1:0] sum_w;
  logic [31:0]     mag_c;

  always_comb begin
    sum_c = SW'(s2_sqx_r) + SW'(s2_sqy_r) + SW'(s2_sqz_r);
    sum_w = CMPW'(sum_c);
    mag_c = (sum_w > CMPW'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sum_w[31:0];
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= 30'(shake_threshold) * 30'(shake_threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_kind_r <= in_kind;
      s1_now_r  <= in_now_ms;
      s1_x_r    <= sat_sub(in_raw_x, offset_x);
      s1_y_r    <= sat_sub(in_raw_y, offset_y);
      s1_z_r    <= sat_sub(in_raw_z, offset_z);
    end
    if (s2_rdy) begin
      s2_kind_r   <= s1_kind_r;
      s2_now_r    <= s1_now_r;
      s2_x_r      <= s1_x_r;
      s2_y_r      <= s1_y_r;
      s2_z_r      <= s1_z_r;
      s2_sqx_r    <= $unsigned(px);
      s2_sqy_r    <= $unsigned(py);
      s2_sqz_r    <= $unsigned(pz);
      s2_orient_r <= orient_c;
      s2_sudden_r <= sudden_c;
    end
    if (s3_rdy) begin
      s3_cls_r.kind        <= s2_kind_r;
      s3_cls_r.now_ms      <= s2_now_r;
      s3_cls_r.mag_sq      <= mag_c;
      s3_cls_r.orientation <= s2_orient_r;
      s3_cls_r.stationary  <= (sum_w >= CMPW'(STILL_LOW_SQ)) &&
                              (sum_w <= CMPW'(STILL_HIGH_SQ));
      s3_cls_r.over_thr    <= sum_w > CMPW'(thr_sq_r);
      s3_cls_r.sudden      <= s2_sudden_r;
      s3_axes_r            <= {s2_x_r, s2_y_r, s2_z_r};
    end
  end

endmodule

[hdl/agod_back.sv]
`timescale 1ns / 1ps
// Back end: shake state, cooldown, stored values and the result register.
// Uses agod_pkg; drained from agod_fifo.
module agod_back
  import agod_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  agod_cls_t            pop_cls,
  input  logic [3*AW-1:0]      pop_axes,
  input  logic                 motion_enable,
  input  logic [15:0]          cooldown_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_updated,
  output logic [1:0]           out_event_res,
  output logic                 out_shake_pulse,
  output logic [2:0]           out_orientation,
  output logic                 out_stationary,
  output logic [31:0]          out_magnitude_sq,
  output logic signed [AW-1:0] out_accel_x,
  output logic signed [AW-1:0] out_accel_y,
  output logic signed [AW-1:0] out_accel_z
);

  logic                 out_valid_r;
  logic                 updated_r, updated_nxt;
  logic                 pulse_r, pulse_nxt;
  logic signed [AW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [31:0]          mag_r, mag_nxt;
  logic [2:0]           orient_r, orient_nxt;
  logic                 still_r, still_nxt;
  logic                 shaking_r, shaking_nxt;
  logic [31:0]          last_shake_r, last_shake_nxt;
  logic [1:0]           event_r, event_nxt;
  logic [31:0]          elapsed;
  logic                 cool_ok;
  logic                 pop;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign elapsed   = pop_cls.now_ms - last_shake_r;
  assign cool_ok   = elapsed >= {16'd0, cooldown_ms};

  always_comb begin
    updated_nxt    = 1'b0;
    pulse_nxt      = 1'b0;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    mag_nxt        = mag_r;
    orient_nxt     = orient_r;
    still_nxt      = still_r;
    shaking_nxt    = shaking_r;
    last_shake_nxt = last_shake_r;
    event_nxt      = event_r;
    if (pop_cls.kind == KIND_CLEAR) begin
      event_nxt      = EV_NONE;
      shaking_nxt    = 1'b0;
      last_shake_nxt = '0;
    end else if (motion_enable) begin
      updated_nxt = 1'b1;
      event_nxt   = EV_NONE;
      x_nxt       = pop_axes[3*AW-1:2*AW];
      y_nxt       = pop_axes[2*AW-1:AW];
      z_nxt       = pop_axes[AW-1:0];
      mag_nxt     = pop_cls.mag_sq;
      orient_nxt  = pop_cls.orientation;
      still_nxt   = pop_cls.stationary;
      // shake edge only outside the cooldown window
      if (cool_ok) begin
        if (pop_cls.over_thr) begin
          if (!shaking_r) begin
            shaking_nxt    = 1'b1;
            last_shake_nxt = pop_cls.now_ms;
            event_nxt      = EV_SHAKE;
            pulse_nxt      = 1'b1;
          end
        end else begin
          shaking_nxt = 1'b0;
        end
      end
      if (pop_cls.sudden) begin
        event_nxt = EV_SUDDEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      x_r          <= '0;
      y_r          <= '0;
      z_r          <= '0;
      mag_r        <= '0;
      orient_r     <= OR_UNKNOWN;
      still_r      <= 1'b0;
      shaking_r    <= 1'b0;
      last_shake_r <= '0;
      event_r      <= EV_NONE;
    end else begin
      if (pop_ready) out_valid_r <= pop_valid;
      if (pop) begin
        x_r          <= x_nxt;
        y_r          <= y_nxt;
        z_r          <= z_nxt;
        mag_r        <= mag_nxt;
        orient_r     <= orient_nxt;
        still_r      <= still_nxt;
        shaking_r    <= shaking_nxt;
        last_shake_r <= last_shake_nxt;
        event_r      <= event_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      updated_r <= updated_nxt;
      pulse_r   <= pulse_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_updated      = updated_r;
  assign out_shake_pulse  = pulse_r;
  assign out_event_res    = event_r;
  assign out_orientation  = orient_r;
  assign out_stationary   = still_r;
  assign out_magnitude_sq = mag_r;
  assign out_accel_x      = x_r;
  assign out_accel_y      = y_r;
  assign out_accel_z      = z_r;

  a_pulse_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_shake_pulse) |-> (out_updated && out_event_res != EV_NONE))
    else $error("shake pulse without update or event");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_cls.kind == KIND_CLEAR) |=> (!shaking_r && last_shake_r == '0))
    else $error("clear word left shake state set");

  a_shake_time: assert property (@(posedge clk) disable iff (!rst_n)
    (last_shake_r != $past(last_shake_r)) |-> $past(pop))
    else $error("shake time changed without a word");

endmodule

[hdl/accel_gesture_orientation_detector.sv]
`timescale 1ns / 1ps
// Accelerometer shake / orientation detector: config registers, front end, queue, back end.
// Uses agod_pkg, agod_front, agod_fifo, agod_back.
// Path: a result word passes three front-end pipeline stages, the queue write and
// the back-end result register after its input word is taken.
// Throughput: one word per cycle unless out_ready stalls; shake state is updated per word.
// Reset (rst_n low, synchronous): clears pipeline, queue, detector state and loads
// config defaults. No clearing pass; the block accepts words right after reset.
module accel_gesture_orientation_detector
  import agod_pkg::*;
#(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic signed [AXIS_WIDTH-1:0] in_raw_x,
  input  logic signed [AXIS_WIDTH-1:0] in_raw_y,
  input  logic signed [AXIS_WIDTH-1:0] in_raw_z,
  input  logic [31:0]                  in_now_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_updated,
  output logic [1:0]                   out_event_res,
  output logic                         out_shake_pulse,
  output logic [2:0]                   out_orientation,
  output logic                         out_stationary,
  output logic [31:0]                  out_magnitude_sq,
  output logic signed [AXIS_WIDTH-1:0] out_accel_x,
  output logic signed [AXIS_WIDTH-1:0] out_accel_y,
  output logic signed [AXIS_WIDTH-1:0] out_accel_z,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [(AXIS_WIDTH > 16 ? AXIS_WIDTH : 16)-1:0] cfg_data
);

  localparam int AW = AXIS_WIDTH;
  localparam int QW = $bits(agod_cls_t) + 3 * AW;

  logic                 motion_enable_r;
  logic [14:0]          shake_threshold_r;
  logic [15:0]          cooldown_ms_r;
  logic signed [AW-1:0] offset_x_r, offset_y_r, offset_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_enable_r   <= ENABLE_RST;
      shake_threshold_r <= THRESHOLD_RST;
      cooldown_ms_r     <= COOLDOWN_RST;
      offset_x_r        <= '0;
      offset_y_r        <= '0;
      offset_z_r        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MOTION_ENABLE:   motion_enable_r   <= cfg_data[0];
        CFG_SHAKE_THRESHOLD: shake_threshold_r <= cfg_data[14:0];
        CFG_COOLDOWN_MS:     cooldown_ms_r     <= cfg_data[15:0];
        CFG_OFFSET_X:        offset_x_r        <= cfg_data[AW-1:0];
        CFG_OFFSET_Y:        offset_y_r        <= cfg_data[AW-1:0];
        CFG_OFFSET_Z:        offset_z_r        <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  logic            push_valid, push_ready;
  agod_cls_t       push_cls;
  logic [3*AW-1:0] push_axes;
  logic            pop_valid, pop_ready;
  logic [QW-1:0]   pop_data;
  agod_cls_t       pop_cls;
  logic [3*AW-1:0] pop_axes;

  agod_front #(.AW(AW)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_raw_x        (in_raw_x),
    .in_raw_y        (in_raw_y),
    .in_raw_z        (in_raw_z),
    .in_now_ms       (in_now_ms),
    .offset_x        (offset_x_r),
    .offset_y        (offset_y_r),
    .offset_z        (offset_z_r),
    .shake_threshold (shake_threshold_r),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cls        (push_cls),
    .push_axes       (push_axes)
  );

  agod_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cls, push_axes}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_cls  = pop_data[QW-1:3*AW];
  assign pop_axes = pop_data[3*AW-1:0];

  agod_back #(.AW(AW)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_cls          (pop_cls),
    .pop_axes         (pop_axes),
    .motion_enable    (motion_enable_r),
    .cooldown_ms      (cooldown_ms_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_updated      (out_updated),
    .out_event_res    (out_event_res),
    .out_shake_pulse  (out_shake_pulse),
    .out_orientation  (out_orientation),
    .out_stationary   (out_stationary),
    .out_magnitude_sq (out_magnitude_sq),
    .out_accel_x      (out_accel_x),
    .out_accel_y      (out_accel_y),
    .out_accel_z      (out_accel_z)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for accel_gesture_orientation_detector: directed and random
// sample/clear words under varied config and handshake stalls. Uses agod_pkg and the RTL.
module tb;
  import agod_pkg::*;

  localparam int AXIS_W = 16;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_SAMPLE;
  logic signed [AXIS_W-1:0] in_raw_x = '0;
  logic signed [AXIS_W-1:0] in_raw_y = '0;
  logic signed [AXIS_W-1:0] in_raw_z = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_updated;
  logic [1:0] out_event_res;
  logic out_shake_pulse;
  logic [2:0] out_orientation;
  logic out_stationary;
  logic [31:0] out_magnitude_sq;
  logic signed [AXIS_W-1:0] out_accel_x;
  logic signed [AXIS_W-1:0] out_accel_y;
  logic signed [AXIS_W-1:0] out_accel_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_MOTION_ENABLE;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 26;
  int recv_idle_pct = 56;
  int quiet_cycles = 0;
  logic [31:0] clock_ms = '0;

  accel_gesture_orientation_detector #(.AXIS_WIDTH(AXIS_W)) dut (.*);

  always #4 clk = ~clk;

  typedef struct {
    logic updated;
    logic [1:0] event_res;
    logic shake_pulse;
    logic [2:0] orientation;
    logic stationary;
    logic [31:0] magnitude_sq;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } motion_result_t;

  class gesture_checker;
    logic enable;
    logic [14:0] thr;
    logic [15:0] cooldown;
    logic signed [AXIS_W-1:0] off[3];
    logic signed [AXIS_W-1:0] acc[3];
    logic shaking;
    logic [31:0] shake_ms;
    logic [1:0] last_ev;
    motion_result_t expected_motion[$];
    int errors, checked, words_in;
    int shakes, suddens, still, held, oriented;

    function new();
      enable = ENABLE_RST;
      thr = THRESHOLD_RST;
      cooldown = COOLDOWN_RST;
      for (int k = 0; k < 3; k++) begin
        off[k] = '0;
        acc[k] = '0;
      end
      shaking = 1'b0;
      shake_ms = '0;
      last_ev = EV_NONE;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        CFG_MOTION_ENABLE: enable = d[0];
        CFG_SHAKE_THRESHOLD: thr = d[14:0];
        CFG_COOLDOWN_MS: cooldown = d;
        CFG_OFFSET_X: off[0] = d;
        CFG_OFFSET_Y: off[1] = d;
        CFG_OFFSET_Z: off[2] = d;
        default: ;
      endcase
    endfunction

    function int size_of(logic signed [AXIS_W-1:0] v);
      return (v < 0) ? -int'(v) : int'(v);
    endfunction

    function logic signed [AXIS_W-1:0] sat_diff(logic signed [AXIS_W-1:0] a,
                                                 logic signed [AXIS_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      if (d > 32767) return 16'sh7fff;
      if (d < -32768) return 16'sh8000;
      return 16'(d);
    endfunction

    function longint energy();
      return longint'(acc[0]) * longint'(acc[0]) + longint'(acc[1]) * longint'(acc[1]) +
             longint'(acc[2]) * longint'(acc[2]);
    endfunction

    // dominant axis must be strictly largest and beyond the limit
    function logic [2:0] facing();
      int ax, ay, az;
      ax = size_of(acc[0]);
      ay = size_of(acc[1]);
      az = size_of(acc[2]);
      if (az > ax && az > ay) begin
        if (acc[2] > ORIENT_LIMIT) return OR_FLAT;
        if (acc[2] < -ORIENT_LIMIT) return OR_UPSIDE;
      end
      if (ay > ax && ay > az) begin
        if (acc[1] > ORIENT_LIMIT) return OR_PORTRAIT;
        if (acc[1] < -ORIENT_LIMIT) return OR_PORT_INV;
      end
      if (ax > ay && ax > az) begin
        if (acc[0] > ORIENT_LIMIT) return OR_LAND_RT;
        if (acc[0] < -ORIENT_LIMIT) return OR_LAND_LT;
      end
      return OR_UNKNOWN;
    endfunction

    function void predict_motion(logic kind, logic signed [AXIS_W-1:0] x,
                                 logic signed [AXIS_W-1:0] y, logic signed [AXIS_W-1:0] z,
                                 logic [31:0] now);
      motion_result_t r;
      longint m;
      logic pulse, upd;
      pulse = 1'b0;
      upd = 1'b0;
      words_in++;
      if (kind == KIND_CLEAR) begin
        last_ev = EV_NONE;
        shaking = 1'b0;
        shake_ms = '0;
      end else if (enable) begin
        upd = 1'b1;
        last_ev = EV_NONE;
        acc[0] = sat_diff(x, off[0]);
        acc[1] = sat_diff(y, off[1]);
        acc[2] = sat_diff(z, off[2]);
        m = energy();
        // elapsed time wraps at 32 bits
        if (now - shake_ms >= {16'd0, cooldown}) begin
          if (m > longint'(thr) * longint'(thr)) begin
            if (!shaking) begin
              shaking = 1'b1;
              shake_ms = now;
              last_ev = EV_SHAKE;
              pulse = 1'b1;
            end
          end else begin
            shaking = 1'b0;
          end
        end
        if (size_of(acc[0]) > SUDDEN_LIMIT || size_of(acc[1]) > SUDDEN_LIMIT ||
            size_of(acc[2]) > SUDDEN_LIMIT)
          last_ev = EV_SUDDEN;
      end
      m = energy();
      r.updated = upd;
      r.event_res = last_ev;
      r.shake_pulse = pulse;
      r.orientation = facing();
      r.stationary = (m >= STILL_LOW_SQ && m <= STILL_HIGH_SQ);
      // cannot exceed 32 bits at a 16-bit axis width
      r.magnitude_sq = m[31:0];
      r.accel_x = acc[0];
      r.accel_y = acc[1];
      r.accel_z = acc[2];
      expected_motion.push_back(r);
    endfunction

    function int pending();
      return expected_motion.size();
    endfunction

    task report(string field, longint want, longint got);
      errors++;
      if (errors <= 100)
        $display("%0t mismatch on result %0d, %s: expected %0d, got %0d",
                 $time, checked, field, want, got);
    endtask

    task check_motion(motion_result_t got);
      motion_result_t want;
      if (expected_motion.size() == 0) begin
        report("result word with nothing expected", 0, 0);
        return;
      end
      want = expected_motion.pop_front();
      checked++;
      if (got.updated !== want.updated) report("updated", want.updated, got.updated);
      if (got.event_res !== want.event_res) report("event_res", want.event_res, got.event_res);
      if (got.shake_pulse !== want.shake_pulse)
        report("shake_pulse", want.shake_pulse, got.shake_pulse);
      if (got.orientation !== want.orientation)
        report("orientation", want.orientation, got.orientation);
      if (got.stationary !== want.stationary)
        report("stationary", want.stationary, got.stationary);
      if (got.magnitude_sq !== want.magnitude_sq)
        report("magnitude_sq", want.magnitude_sq, got.magnitude_sq);
      if (got.accel_x !== want.accel_x) report("accel_x", want.accel_x, got.accel_x);
      if (got.accel_y !== want.accel_y) report("accel_y", want.accel_y, got.accel_y);
      if (got.accel_z !== want.accel_z) report("accel_z", want.accel_z, got.accel_z);
      if (want.shake_pulse) shakes++;
      if (want.event_res == EV_SUDDEN) suddens++;
      if (want.stationary) still++;
      if (!want.updated) held++;
      if (want.orientation != OR_UNKNOWN) oriented++;
    endtask
  endclass

  gesture_checker sb;

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    motion_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.updated = out_updated;
      got.event_res = out_event_res;
      got.shake_pulse = out_shake_pulse;
      got.orientation = out_orientation;
      got.stationary = out_stationary;
      got.magnitude_sq = out_magnitude_sq;
      got.accel_x = out_accel_x;
      got.accel_y = out_accel_y;
      got.accel_z = out_accel_z;
      sb.check_motion(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic kind, input logic signed [AXIS_W-1:0] x,
                           input logic signed [AXIS_W-1:0] y,
                           input logic signed [AXIS_W-1:0] z, input logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_motion(kind, x, y, z, now);
  endtask

  // hold the sender until every outstanding word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic configure(input logic en, input logic [15:0] thr_w, input logic [15:0] cd,
                           input logic [15:0] ox, input logic [15:0] oy,
                           input logic [15:0] oz);
    drain();
    write_reg(CFG_MOTION_ENABLE, {15'd0, en});
    write_reg(CFG_SHAKE_THRESHOLD, thr_w);
    write_reg(CFG_COOLDOWN_MS, cd);
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_OFFSET_Z, oz);
    cfg_valid <= 1'b0;
  endtask

  // raw value that lands on the wanted corrected value where it can
  function automatic logic signed [AXIS_W-1:0] to_raw(int want, logic signed [AXIS_W-1:0] o);
    int r;
    r = want + int'(o);
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic send_random();
    int sel, base, ax;
    int v[3];
    int edges[12] = '{0, 896, 897, -896, -897, 1536, 1537, -1536, -1537, 1256, 32767, -32768};
    logic signed [AXIS_W-1:0] r[3];
    logic knd;
    if ($urandom_range(0, 39) == 0) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, 250);
    sel = $urandom_range(0, 99);
    knd = KIND_SAMPLE;
    base = int'(sb.thr) * 148 / 256;
    ax = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      if (sel < 45) begin
        // near gravity on one axis
        v[k] = int'($urandom_range(0, 300)) - 150;
        if (k == ax) v[k] = 1256 + int'($urandom_range(0, 400)) - 200;
      end else if (sel < 75) begin
        // magnitude straddling the shake threshold
        v[k] = base + int'($urandom_range(0, 80)) - 40;
      end else begin
        v[k] = edges[$urandom_range(0, 11)];
      end
      if (sel < 75 && $urandom_range(0, 1)) v[k] = -v[k];
      r[k] = (sel < 10 || sel >= 88) ? 16'($urandom()) : to_raw(v[k], sb.off[k]);
    end
    if (sel < 10) knd = KIND_CLEAR;
    send_word(knd, r[0], r[1], r[2], clock_ms);
  endtask

  initial begin
    int n_items, hold_at;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // orientation, stillness, cooldown and saturation corners at reset config
    send_word(KIND_SAMPLE, 0, 0, 0, 0);
    send_word(KIND_SAMPLE, 0, 0, 1256, 10);
    send_word(KIND_SAMPLE, 0, 0, -1000, 20);
    send_word(KIND_SAMPLE, 0, 1000, 0, 30);
    send_word(KIND_SAMPLE, 0, -1000, 0, 40);
    send_word(KIND_SAMPLE, 1000, 0, 0, 50);
    send_word(KIND_SAMPLE, -1000, 0, 0, 60);
    send_word(KIND_SAMPLE, 1000, 1000, 0, 70);
    send_word(KIND_SAMPLE, 0, 0, 896, 80);
    send_word(KIND_SAMPLE, 0, 0, -897, 90);
    send_word(KIND_SAMPLE, 1500, 1500, 1500, 600);
    send_word(KIND_SAMPLE, 1500, 1500, 1500, 700);
    send_word(KIND_SAMPLE, 1500, 1500, 1500, 1200);
    send_word(KIND_SAMPLE, 0, 0, 0, 1300);
    send_word(KIND_SAMPLE, 1500, 1500, 1500, 1400);
    send_word(KIND_SAMPLE, 2000, 0, 0, 1500);
    send_word(KIND_SAMPLE, 32767, 32767, 32767, 1510);
    send_word(KIND_SAMPLE, -32768, -32768, -32768, 1520);
    send_word(KIND_CLEAR, 16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom());
    send_word(KIND_SAMPLE, 1500, 1500, 1500, 32'hffff_ff00);
    send_word(KIND_SAMPLE, 1500, 1500, 1500, 32'h0000_0010);
    send_word(KIND_SAMPLE, 1500, 1500, 1500, 32'h0000_0200);
    configure(1'b0, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'd100);
    send_word(KIND_SAMPLE, 32767, 32767, 32767, 32'h0000_0300);
    send_word(KIND_CLEAR, 0, 0, 0, 0);
    configure(1'b1, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'd100);
    send_word(KIND_SAMPLE, 32767, -32768, 0, 32'h0000_0400);
    send_word(KIND_SAMPLE, 32767, -32768, 0, 32'h0000_0401);
    send_word(KIND_SAMPLE, -32768, 32767, 100, 32'h0000_0402);

    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 26;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1: configure(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: configure(1'b1, 16'hffff, 16'hffff, 16'(int'($urandom_range(0, 400)) - 200),
                     16'(int'($urandom_range(0, 400)) - 200), 16'd0);
        4: configure(1'b1, 16'($urandom_range(1000, 4000)), 16'($urandom_range(0, 800)),
                     16'h8000, 16'h7fff, 16'($urandom()));
        5: configure(1'b0, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                     16'($urandom()), 16'($urandom()));
        default: configure(1'b1, 16'($urandom_range(1000, 4000)), 16'($urandom_range(0, 800)),
                           16'(int'($urandom_range(0, 400)) - 200),
                           16'(int'($urandom_range(0, 400)) - 200),
                           16'(int'($urandom_range(0, 400)) - 200));
      endcase
      n_items = (p == 5) ? 40 : 125;
      hold_at = $urandom_range(10, n_items - 10);
      for (int i = 0; i < n_items; i++) begin
        if (i == hold_at) drain();
        send_random();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("checked %0d of %0d words: %0d shake pulses, %0d sudden, %0d stationary,",
             sb.checked, sb.words_in, sb.shakes, sb.suddens, sb.still);
    $display("  %0d with a known orientation, %0d held while disabled or cleared",
             sb.oriented, sb.held);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
